FILE: hdl/rcaf_pkg.sv
package rcaf_pkg;

   localparam int CHUNK_COUNT_DEF = 16;
   localparam int CS_W            = 32;
   localparam int SIZE_W          = 48;
   localparam int FENCE_W         = 64;
   localparam int OFFSET_W        = 40;
   localparam int DIV_CNT_W       = 6;

   localparam logic [CS_W-1:0]      CHUNK_SIZE_RST = 32'd1048576;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST       = 6'(SIZE_W - 1);

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_SET   = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_SIZE  = 2'd1,
      STATUS_PHASE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_CHECK,
      S_SCAN,
      S_FILL,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic       load;
      logic       div_step;
      logic       commit;
      logic       scan;
      logic       fill;
      logic       status_we;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic awaiting;
      logic div_done;
      logic oversize;
      logic scan_done;
      logic fill_last;
   } dp_stat_type;

endpackage

FILE: hdl/rcaf_ram.sv
module rcaf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/rcaf_ctrl.sv
module rcaf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_kind,
   input  rcaf_pkg::dp_stat_type stat,
   output rcaf_pkg::dp_cmd_type  cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   rcaf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcaf_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rcaf_pkg::S_IDLE: begin
            if (start) begin
               if (req_kind == rcaf_pkg::KIND_ALLOC) begin
                  state_in = rcaf_pkg::S_DIV;
               end else if (stat.awaiting) begin
                  state_in = rcaf_pkg::S_FILL;
               end else begin
                  state_in = rcaf_pkg::S_REPLY;
               end
            end
         end
         rcaf_pkg::S_DIV: begin
            if (stat.div_done) begin
               state_in = rcaf_pkg::S_CHECK;
            end
         end
         rcaf_pkg::S_CHECK: begin
            if (stat.oversize || stat.awaiting) begin
               state_in = rcaf_pkg::S_REPLY;
            end else begin
               state_in = rcaf_pkg::S_SCAN;
            end
         end
         rcaf_pkg::S_SCAN: begin
            if (stat.scan_done) begin
               state_in = rcaf_pkg::S_REPLY;
            end
         end
         rcaf_pkg::S_FILL: begin
            if (stat.fill_last) begin
               state_in = rcaf_pkg::S_REPLY;
            end
         end
         rcaf_pkg::S_REPLY: begin
            state_in = rcaf_pkg::S_IDLE;
         end
         default: begin
            state_in = rcaf_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.status = rcaf_pkg::STATUS_OK;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         rcaf_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (req_kind == rcaf_pkg::KIND_SET && !stat.awaiting) begin
                  cmd.status_we = 1'b1;
                  cmd.status    = rcaf_pkg::STATUS_PHASE;
               end
            end
         end
         rcaf_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
         end
         rcaf_pkg::S_CHECK: begin
            cmd.status_we = 1'b1;
            if (stat.oversize) begin
               cmd.status = rcaf_pkg::STATUS_SIZE;
            end else if (stat.awaiting) begin
               cmd.status = rcaf_pkg::STATUS_PHASE;
            end else begin
               cmd.commit = 1'b1;
               cmd.status = rcaf_pkg::STATUS_OK;
            end
         end
         rcaf_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
         end
         rcaf_pkg::S_FILL: begin
            cmd.fill = 1'b1;
            if (stat.fill_last) begin
               cmd.status_we = 1'b1;
               cmd.status    = rcaf_pkg::STATUS_OK;
            end
         end
         rcaf_pkg::S_REPLY: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a word");

   a_check_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rcaf_pkg::S_CHECK) |-> ($past(state_ff) == rcaf_pkg::S_DIV))
      else $error("size check entered without a division");

endmodule

FILE: hdl/rcaf_dp.sv
module rcaf_dp #(
   parameter int CHUNK_COUNT = rcaf_pkg::CHUNK_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rcaf_pkg::dp_cmd_type              cmd,
   output rcaf_pkg::dp_stat_type             stat,
   input  logic [rcaf_pkg::CS_W-1:0]         chunk_size,
   input  logic                              req_kind,
   input  logic [rcaf_pkg::SIZE_W-1:0]       req_alloc_size,
   input  logic [rcaf_pkg::FENCE_W-1:0]      req_fence_value,
   output logic [1:0]                        rsp_status,
   output logic [rcaf_pkg::OFFSET_W-1:0]     rsp_byte_offset,
   output logic [rcaf_pkg::FENCE_W-1:0]      rsp_wait_fence,
   output logic                              rsp_repeat_fence
);

   localparam int IW = $clog2(CHUNK_COUNT);
   localparam int CW = $clog2(CHUNK_COUNT + 1);
   localparam int SW = CW + 1;
   localparam int PW = IW + rcaf_pkg::CS_W;
   localparam logic [SW-1:0] N_S     = SW'(CHUNK_COUNT);
   localparam logic [SW-1:0] HALF_S  = SW'(CHUNK_COUNT / 2);
   localparam logic [SW-1:0] HALF2_S = SW'(2 * (CHUNK_COUNT / 2));
   localparam logic [rcaf_pkg::SIZE_W-1:0] N_Q = rcaf_pkg::SIZE_W'(CHUNK_COUNT);

   // Control state.
   logic                            awaiting_ff, awaiting_in;
   logic [IW-1:0]                   first_free_ff, first_free_in;
   logic [IW-1:0]                   last_run_start_ff, last_run_start_in;
   logic [rcaf_pkg::FENCE_W-1:0]    last_fence_ff, last_fence_in;
   logic [CHUNK_COUNT-1:0]          vld_ff, vld_in;
   logic [rcaf_pkg::DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [CW-1:0]                   scan_cnt_ff, scan_cnt_in;
   logic                            rd_pend_ff, rd_pend_in;
   rcaf_pkg::status_type            status_ff, status_in;
   logic                            kind_ff, kind_in;

   // Payload.
   logic [rcaf_pkg::SIZE_W-1:0]     quo_ff, quo_in;
   logic [rcaf_pkg::CS_W-1:0]       rem_ff, rem_in;
   logic [IW-1:0]                   first_ff, first_in;
   logic [CW-1:0]                   len_ff, len_in;
   logic [IW-1:0]                   scan_idx_ff, scan_idx_in;
   logic [IW-1:0]                   fill_idx_ff, fill_idx_in;
   logic                            vld_rd_ff, vld_rd_in;
   logic [rcaf_pkg::FENCE_W-1:0]    wait_ff, wait_in;
   logic [rcaf_pkg::FENCE_W-1:0]    fval_ff, fval_in;
   logic [rcaf_pkg::OFFSET_W-1:0]   offset_ff, offset_in;

   logic [rcaf_pkg::CS_W-1:0]       cs;
   logic [rcaf_pkg::CS_W:0]         div_shift;
   logic                            div_ge;
   logic                            rem_nz;
   logic [CW-1:0]                   len_c;
   logic [SW-1:0]                   ff_s, len_s, end_raw, end_s, first_s, nxt_s;
   logic [1:0]                      sh, eh;
   logic [SW-1:0]                   eh_start;
   logic [CW-1:0]                   stop;
   logic                            scan_issue;
   logic [PW-1:0]                   prod;
   logic [rcaf_pkg::FENCE_W-1:0]    ram_q, rd_val;
   logic                            alloc_ok;

   assign cs = (chunk_size == '0) ? rcaf_pkg::CS_W'(1) : chunk_size;

   // Restoring division, one quotient bit per cycle.
   assign div_shift = {rem_ff, quo_ff[rcaf_pkg::SIZE_W-1]};
   assign div_ge    = div_shift >= {1'b0, cs};

   // Chunk count is the quotient rounded up; zero bytes still take one chunk.
   assign rem_nz        = rem_ff != '0;
   assign stat.oversize = (quo_ff > N_Q) || ((quo_ff == N_Q) && rem_nz);
   assign len_c = (quo_ff == '0) ? CW'(1) : quo_ff[CW-1:0] + CW'(rem_nz);

   // Run placement.
   assign ff_s    = SW'(first_free_ff);
   assign len_s   = SW'(len_c);
   assign end_raw = ff_s + len_s - SW'(1);
   assign end_s   = (end_raw >= N_S) ? end_raw - N_S : end_raw;
   assign sh      = (ff_s >= HALF2_S) ? 2'd2 : ((ff_s >= HALF_S) ? 2'd1 : 2'd0);
   assign eh      = (end_s >= HALF2_S) ? 2'd2 : ((end_s >= HALF_S) ? 2'd1 : 2'd0);

   always_comb begin
      case (eh)
         2'd0:    eh_start = '0;
         2'd1:    eh_start = HALF_S;
         default: eh_start = HALF2_S;
      endcase
   end

   always_comb begin
      if (len_s > HALF_S) begin
         first_s = (end_s > ff_s) ? ff_s : '0;
      end else begin
         first_s = (sh == eh) ? ff_s : eh_start;
         if (first_s + len_s > N_S) begin
            first_s = '0;
         end
      end
      nxt_s = first_s + len_s;
      if (nxt_s >= N_S) begin
         nxt_s = nxt_s - N_S;
      end
   end

   assign stop       = (first_free_ff == '0) ? CW'(CHUNK_COUNT) : CW'(first_free_ff);
   assign scan_issue = scan_cnt_ff != len_ff;
   assign rd_val     = vld_rd_ff ? ram_q : '0;
   assign prod       = PW'(first_ff) * PW'(cs);

   assign stat.awaiting  = awaiting_ff;
   assign stat.div_done  = div_cnt_ff == rcaf_pkg::DIV_LAST;
   assign stat.scan_done = !scan_issue && !rd_pend_ff;
   assign stat.fill_last = (SW'(fill_idx_ff) + SW'(1)) == SW'(stop);

   always_comb begin
      awaiting_in       = awaiting_ff;
      first_free_in     = first_free_ff;
      last_run_start_in = last_run_start_ff;
      last_fence_in     = last_fence_ff;
      vld_in            = vld_ff;
      div_cnt_in        = div_cnt_ff;
      scan_cnt_in       = scan_cnt_ff;
      rd_pend_in        = 1'b0;
      status_in         = status_ff;
      kind_in           = kind_ff;
      quo_in            = quo_ff;
      rem_in            = rem_ff;
      first_in          = first_ff;
      len_in            = len_ff;
      scan_idx_in       = scan_idx_ff;
      fill_idx_in       = fill_idx_ff;
      vld_rd_in         = vld_rd_ff;
      wait_in           = wait_ff;
      fval_in           = fval_ff;
      offset_in         = rcaf_pkg::OFFSET_W'(prod);

      if (cmd.load) begin
         kind_in     = req_kind;
         quo_in      = req_alloc_size;
         rem_in      = '0;
         div_cnt_in  = '0;
         fval_in     = req_fence_value;
         fill_idx_in = last_run_start_ff;
      end
      if (cmd.div_step) begin
         quo_in     = {quo_ff[rcaf_pkg::SIZE_W-2:0], div_ge};
         rem_in     = div_ge ? rcaf_pkg::CS_W'(div_shift - {1'b0, cs})
                             : div_shift[rcaf_pkg::CS_W-1:0];
         div_cnt_in = div_cnt_ff + rcaf_pkg::DIV_CNT_W'(1);
      end
      if (cmd.commit) begin
         first_in          = IW'(first_s);
         len_in            = len_c;
         first_free_in     = IW'(nxt_s);
         last_run_start_in = IW'(first_s);
         awaiting_in       = 1'b1;
         scan_idx_in       = IW'(first_s);
         scan_cnt_in       = '0;
         wait_in           = '0;
      end
      if (cmd.scan) begin
         if (scan_issue) begin
            vld_rd_in   = vld_ff[scan_idx_ff];
            scan_idx_in = IW'(SW'(scan_idx_ff) + SW'(1));
            scan_cnt_in = scan_cnt_ff + CW'(1);
            rd_pend_in  = 1'b1;
         end
         if (rd_pend_ff && (rd_val > wait_ff)) begin
            wait_in = rd_val;
         end
      end
      if (cmd.fill) begin
         vld_in[fill_idx_ff] = 1'b1;
         fill_idx_in         = IW'(SW'(fill_idx_ff) + SW'(1));
         if (stat.fill_last) begin
            awaiting_in   = 1'b0;
            last_fence_in = fval_ff;
         end
      end
      if (cmd.status_we) begin
         status_in = cmd.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff       <= 1'b0;
         first_free_ff     <= '0;
         last_run_start_ff <= '0;
         last_fence_ff     <= '0;
         vld_ff            <= '0;
         div_cnt_ff        <= '0;
         scan_cnt_ff       <= '0;
         rd_pend_ff        <= 1'b0;
         status_ff         <= rcaf_pkg::STATUS_OK;
         kind_ff           <= rcaf_pkg::KIND_ALLOC;
      end else begin
         awaiting_ff       <= awaiting_in;
         first_free_ff     <= first_free_in;
         last_run_start_ff <= last_run_start_in;
         last_fence_ff     <= last_fence_in;
         vld_ff            <= vld_in;
         div_cnt_ff        <= div_cnt_in;
         scan_cnt_ff       <= scan_cnt_in;
         rd_pend_ff        <= rd_pend_in;
         status_ff         <= status_in;
         kind_ff           <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      first_ff    <= first_in;
      len_ff      <= len_in;
      scan_idx_ff <= scan_idx_in;
      fill_idx_ff <= fill_idx_in;
      vld_rd_ff   <= vld_rd_in;
      wait_ff     <= wait_in;
      fval_ff     <= fval_in;
      offset_ff   <= offset_in;
   end

   rcaf_ram #(
      .WIDTH(rcaf_pkg::FENCE_W),
      .DEPTH(CHUNK_COUNT)
   ) u_fence_ram (
      .clock  (clock),
      .wr_en  (cmd.fill),
      .wr_addr(fill_idx_ff),
      .wr_data(fval_ff),
      .rd_en  (cmd.scan && scan_issue),
      .rd_addr(scan_idx_ff),
      .rd_data(ram_q)
   );

   // Set words and failed requests report zeros beyond the status.
   assign alloc_ok         = (status_ff == rcaf_pkg::STATUS_OK) &&
                             (kind_ff == rcaf_pkg::KIND_ALLOC);
   assign rsp_status       = status_ff;
   assign rsp_byte_offset  = alloc_ok ? offset_ff : '0;
   assign rsp_wait_fence   = alloc_ok ? wait_ff : '0;
   assign rsp_repeat_fence = alloc_ok && (wait_ff == last_fence_ff) &&
                             (last_fence_ff != '0);

   a_run_in_ring: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (SW'(last_run_start_ff) + SW'(len_ff)) <= N_S)
      else $error("allocated run extends past the last chunk");

   a_fill_in_run: assert property (@(posedge clock) disable iff (reset)
      cmd.fill |-> (SW'(fill_idx_ff) < SW'(stop)))
      else $error("fence write outside the last run");

   a_awaiting_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(awaiting_ff) |-> $past(cmd.commit))
      else $error("fence phase entered without an allocation");

endmodule

FILE: hdl/ring_chunk_allocator_with_fences.sv
// Channel  Direction  Handshake                 Word
// request  in         start && !busy            req_kind, req_alloc_size, req_fence_value
// result   out        rsp_valid, one cycle      rsp_status, rsp_byte_offset,
//                                               rsp_wait_fence, rsp_repeat_fence
// config   in         psel, penable, pwrite     paddr, pwdata, prdata (pready tied high)
//
// An allocate word goes from accept to result through a 48-bit bit-serial divider
// by chunk_size, a placement check, then one fence memory read per chunk of the
// run. An oversized or out-of-phase allocate answers straight after the division
// and check; a set word writes one chunk per cycle and answers in the cycle after
// its last write, and an out-of-phase set answers on the next cycle.
// Reset is synchronous and clears the fence valid bits at once, so no clearing
// pass is needed. Results cannot be stalled; busy stays high until the result
// cycle is over.
module ring_chunk_allocator_with_fences #(
   parameter int CHUNK_COUNT = rcaf_pkg::CHUNK_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_kind,
   input  logic [rcaf_pkg::SIZE_W-1:0]    req_alloc_size,
   input  logic [rcaf_pkg::FENCE_W-1:0]   req_fence_value,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic [rcaf_pkg::OFFSET_W-1:0]  rsp_byte_offset,
   output logic [rcaf_pkg::FENCE_W-1:0]   rsp_wait_fence,
   output logic                           rsp_repeat_fence,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [2:0]                     paddr,
   input  logic [rcaf_pkg::CS_W-1:0]      pwdata,
   output logic [rcaf_pkg::CS_W-1:0]      prdata,
   output logic                           pready
);

   logic [rcaf_pkg::CS_W-1:0] chunk_size_ff, chunk_size_in;
   logic                      csr_wr;
   rcaf_pkg::dp_cmd_type      cmd;
   rcaf_pkg::dp_stat_type     stat;

   // The only register lives at byte address 0; address bit 2 selects beyond it.
   assign pready        = 1'b1;
   assign csr_wr        = psel && penable && pwrite && pready && !paddr[2];
   assign chunk_size_in = csr_wr ? pwdata : chunk_size_ff;
   assign prdata        = paddr[2] ? '0 : chunk_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= rcaf_pkg::CHUNK_SIZE_RST;
      end else begin
         chunk_size_ff <= chunk_size_in;
      end
   end

   rcaf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid)
   );

   rcaf_dp #(
      .CHUNK_COUNT(CHUNK_COUNT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .chunk_size      (chunk_size_ff),
      .req_kind        (req_kind),
      .req_alloc_size  (req_alloc_size),
      .req_fence_value (req_fence_value),
      .rsp_status      (rsp_status),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_wait_fence  (rsp_wait_fence),
      .rsp_repeat_fence(rsp_repeat_fence)
   );

endmodule
